// ===== src/tgsbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tgsbc_pkg
// Shared types, constants and helpers of the tile grid swept box collision.
// ----------------------------------------------------------------------------
package tgsbc_pkg;

  // grid geometry
  localparam int unsigned COL_BITS  = 6;
  localparam int unsigned ROW_BITS  = 6;
  localparam int unsigned ADDR_BITS = COL_BITS + ROW_BITS;
  localparam int unsigned COLS_MAX  = 1 << COL_BITS;
  localparam int unsigned ROWS_MAX  = 1 << ROW_BITS;
  localparam int unsigned FRAC_BITS = 4;

  // divider widths: dividend magnitude, divisor, signed quotient
  localparam int unsigned DVD_W = 20;
  localparam int unsigned DSR_W = 9 + FRAC_BITS;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned QS_W  = DVD_W + 1;

  // wall bits of a tile flag byte
  localparam int unsigned WALL_N = 0;
  localparam int unsigned WALL_E = 1;
  localparam int unsigned WALL_S = 2;
  localparam int unsigned WALL_W = 3;

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_CLR     = 2'd1,
    CMD_SWEEP_H = 2'd2,
    CMD_SWEEP_V = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MAP_W  = 2'd0,
    REG_MAP_H  = 2'd1,
    REG_TILE_W = 2'd2,
    REG_TILE_H = 2'd3
  } reg_e;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    logic       we;
    addr_t      waddr;
    logic [7:0] wdata;
    addr_t      raddr;
  } mem_req_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quo;
    logic             rem_nz;
  } div_rsp_t;

  // saturate to 18 bits signed
  function automatic logic [17:0] sat18(input logic signed [QS_W-1:0] v);
    logic [17:0] r;
    if (v > QS_W'(131071)) r = 18'h1FFFF;
    else if (v < -QS_W'(131072)) r = 18'h20000;
    else r = v[17:0];
    return r;
  endfunction

  // saturate to 14 bits signed
  function automatic logic [13:0] sat14(input logic signed [QS_W-1:0] v);
    logic [13:0] r;
    if (v > QS_W'(8191)) r = 14'h1FFF;
    else if (v < -QS_W'(8192)) r = 14'h2000;
    else r = v[13:0];
    return r;
  endfunction

endpackage

// ===== src/tgsbc_tile_mem.sv =====
// ----------------------------------------------------------------------------
// tgsbc_tile_mem
// Tile flag store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tgsbc_tile_mem
  import tgsbc_pkg::*;
(
  input  logic       clk_i,
  input  mem_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [COLS_MAX*ROWS_MAX];

  // write
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

// ===== src/tgsbc_div.sv =====
// ----------------------------------------------------------------------------
// tgsbc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tgsbc_div
  import tgsbc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] acc_q, acc_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W:0]   shifted;
  logic             fits;

  // one restoring step
  assign shifted = {rem_q, acc_q[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? DSR_W'(shifted - {1'b0, dsr_q}) : shifted[DSR_W-1:0];
      acc_d = {acc_q[DVD_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quo    = acc_q;
  assign rsp_o.rem_nz = |rem_q;

endmodule

// ===== src/tile_grid_swept_box_collision.sv =====
// ----------------------------------------------------------------------------
// tile_grid_swept_box_collision
// Tile flag grid with set/clear commands and swept box collision per axis.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+--------------------------
//  s_axis    | in        | tvalid/tready              | tdata 152b, tuser command
//  m_axis    | out       | tvalid/tready              | tdata 56b, tuser hit
//  cfg       | in        | cfg_we_i, no wait          | cfg_idx_i, cfg_data_i
//
//  After reset a clearing pass writes all 4096 tiles to zero, during which no
//  request is taken. A flag request reads the tile, then writes it back. A
//  sweep runs its four serial divisions, then for each span tile at each
//  visited boundary reads the flag memory twice (it has one read port) and
//  checks the pair, with a hit state on a hit. One request is in work at a time;
//  a result waits in the output register while the next is taken.
//
module tile_grid_swept_box_collision
  import tgsbc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // fields: start_x[17:0] start_y[35:18] end_x[53:36] end_y[71:54]
  // start_w[87:72] start_h[103:88] end_w[119:104] end_h[135:120]
  // positive_dir[136] flags[144:137], zero pad to 151
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [151:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,   // command[1:0]
  // fields: resolved_pos[17:0] boundary_index[25:18] hit_solid[26]
  // span_start[40:27] span_end[54:41], zero pad at 55
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata,
  output logic         m_axis_tuser,   // hit
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [8:0]   cfg_data_i
);

  typedef enum logic [12:0] {
    S_CLEAR   = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_FLAG_RD = 13'b0000000000100,
    S_FLAG_WR = 13'b0000000001000,
    S_PREP    = 13'b0000000010000,
    S_DIV     = 13'b0000000100000,
    S_DIVW    = 13'b0000001000000,
    S_BND     = 13'b0000010000000,
    S_RDA     = 13'b0000100000000,
    S_RDB     = 13'b0001000000000,
    S_CHK     = 13'b0010000000000,
    S_HIT     = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [6:0] map_w_q, map_h_q;
  logic [8:0] tile_w_q, tile_h_q;
  logic [6:0] cols_used, rows_used;
  logic [DSR_W-1:0] tw_lsb, th_lsb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q  <= 7'd64;
      map_h_q  <= 7'd64;
      tile_w_q <= 9'd16;
      tile_h_q <= 9'd16;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_MAP_W:  map_w_q  <= cfg_data_i[6:0];
        REG_MAP_H:  map_h_q  <= cfg_data_i[6:0];
        REG_TILE_W: tile_w_q <= cfg_data_i;
        REG_TILE_H: tile_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cols_used = (map_w_q > 7'(COLS_MAX)) ? 7'(COLS_MAX) : map_w_q;
  assign rows_used = (map_h_q > 7'(ROWS_MAX)) ? 7'(ROWS_MAX) : map_h_q;
  assign tw_lsb = {(tile_w_q == '0) ? 9'd1 : tile_w_q, FRAC_BITS'(0)};
  assign th_lsb = {(tile_h_q == '0) ? 9'd1 : tile_h_q, FRAC_BITS'(0)};

  // input field unpack
  logic signed [17:0] in_sx, in_sy, in_ex, in_ey;
  logic [15:0] in_sw, in_sh, in_ew, in_eh;
  logic        in_pos, in_vert, accept;
  logic [7:0]  in_flags;
  logic        in_tile_ok;

  assign in_sx    = s_axis_tdata[17:0];
  assign in_sy    = s_axis_tdata[35:18];
  assign in_ex    = s_axis_tdata[53:36];
  assign in_ey    = s_axis_tdata[71:54];
  assign in_sw    = s_axis_tdata[87:72];
  assign in_sh    = s_axis_tdata[103:88];
  assign in_ew    = s_axis_tdata[119:104];
  assign in_eh    = s_axis_tdata[135:120];
  assign in_pos   = s_axis_tdata[136];
  assign in_flags = s_axis_tdata[144:137];
  assign in_vert  = (cmd_e'(s_axis_tuser) == CMD_SWEEP_V);
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_tile_ok = !in_sx[17] && !in_sy[17]
                   && (in_sx < $signed({11'b0, cols_used}))
                   && (in_sy < $signed({11'b0, rows_used}));

  // request registers
  logic               is_flag_q, is_clr_q, tile_ok_q, pos_q, vert_q;
  addr_t              tile_addr_q;
  logic [7:0]         flags_q;
  logic signed [17:0] sp_q, ep_q, sq_q, eq_q;
  logic [15:0]        ss_q, es_q, sqs_q, eqs_q;
  logic [DSR_W-1:0]   ta_q, tq_q;
  logic [6:0]         ma_q, mq_q;

  // sweep working registers
  logic signed [DVD_W-1:0] sedge_q, eedge_q, qmin_q, qmax_q;
  logic [1:0]              div_sel_q;
  logic signed [QS_W-1:0]  span0_q, span1_q, lo_q, hi_q, b_q, b1_q;
  logic [6:0]              k_q;
  logic                    va_q, vb_q, solid_q;
  logic [7:0]              fa_q;
  logic [19:0]             prod_q;

  // result registers
  logic        res_hit_q, res_solid_q;
  logic [17:0] res_pos_q;
  logic [7:0]  res_bnd_q;
  logic [13:0] res_s0_q, res_s1_q;

  // output registers
  logic        out_valid_q, out_hit_q, out_solid_q;
  logic [17:0] out_pos_q;
  logic [7:0]  out_bnd_q;
  logic [13:0] out_s0_q, out_s1_q;

  // clearing pass
  logic [ADDR_BITS-1:0] clr_cnt_q;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  tgsbc_tile_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  tgsbc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // edges of the leading side
  logic signed [DVD_W-1:0] s_edge, e_edge, qa, qb, qmin_c, qmax_c;
  assign s_edge = pos_q ? DVD_W'(sp_q) + $signed({4'b0, ss_q}) : DVD_W'(sp_q);
  assign e_edge = pos_q ? DVD_W'(ep_q) + $signed({4'b0, es_q}) : DVD_W'(ep_q);
  assign qa     = DVD_W'(sq_q) + $signed({4'b0, sqs_q});
  assign qb     = DVD_W'(eq_q) + $signed({4'b0, eqs_q});
  assign qmin_c = (sq_q < eq_q) ? DVD_W'(sq_q) : DVD_W'(eq_q);
  assign qmax_c = ((qa > qb) ? qa : qb) - DVD_W'(1);

  // divider operand select
  logic signed [DVD_W-1:0] dvd_sel;
  logic                    dvd_neg_q;
  always_comb begin
    unique case (div_sel_q)
      2'd0:    dvd_sel = qmin_q;
      2'd1:    dvd_sel = qmax_q;
      2'd2:    dvd_sel = sedge_q;
      default: dvd_sel = eedge_q;
    endcase
  end

  assign div_req.start    = (state_q == S_DIV);
  assign div_req.dividend = dvd_sel[DVD_W-1] ? DVD_W'(-dvd_sel) : dvd_sel;
  assign div_req.divisor  = div_sel_q[1] ? ta_q : tq_q;

  // signed floor or ceiling from the magnitude quotient
  logic                   use_floor;
  logic signed [QS_W-1:0] q_mag, q_fix;
  assign use_floor = !div_sel_q[1] || (div_sel_q[0] ? pos_q : !pos_q);
  assign q_mag = dvd_neg_q ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
  assign q_fix = use_floor ? q_mag - QS_W'(dvd_neg_q && div_rsp.rem_nz)
                           : q_mag + QS_W'(!dvd_neg_q && div_rsp.rem_nz);

  // boundary loop condition
  logic loop_go;
  assign loop_go = (lo_q <= hi_q) && (pos_q ? (b_q <= b1_q) : (b_q >= b1_q));

  // tile address along the sweep axis
  logic signed [QS_W-1:0] along;
  logic                   along_ok;
  addr_t                  tile_raddr;
  assign along    = (state_q == S_RDA) ? b_q - QS_W'(1) : b_q;
  assign along_ok = !along[QS_W-1] && (along < $signed({14'b0, ma_q}));
  assign tile_raddr = vert_q ? {along[ROW_BITS-1:0], k_q[COL_BITS-1:0]}
                             : {k_q[ROW_BITS-1:0], along[COL_BITS-1:0]};

  // memory port
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = tile_addr_q;
    mem_req.wdata = is_clr_q ? (mem_rdata & ~flags_q) : (mem_rdata | flags_q);
    mem_req.raddr = (state_q == S_FLAG_RD) ? tile_addr_q : tile_raddr;
    if (state_q == S_CLEAR) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = clr_cnt_q;
      mem_req.wdata = '0;
    end else if (state_q == S_FLAG_WR) begin
      mem_req.we = tile_ok_q;
    end
  end

  // tile check on the pair before and after the boundary
  logic [7:0] fb;
  logic       blk, solid_now;
  assign fb  = vb_q ? mem_rdata : 8'h00;
  assign blk = vert_q ? (fa_q[WALL_S] || fb[WALL_N]) : (fa_q[WALL_E] || fb[WALL_W]);
  assign solid_now = (&fa_q[3:0]) || (&fb[3:0]);

  // hit position
  logic signed [QS_W-1:0] hit_pos;
  assign hit_pos = pos_q ? $signed({1'b0, prod_q}) - QS_W'(1) - $signed({5'b0, ss_q})
                         : $signed({1'b0, prod_q}) + QS_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:   if (&clr_cnt_q) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          state_d = (s_axis_tuser[1] == 1'b0) ? S_FLAG_RD : S_PREP;
        end
      end
      S_FLAG_RD: state_d = S_FLAG_WR;
      S_FLAG_WR: state_d = S_DONE;
      S_PREP:    state_d = (s_edge == e_edge) ? S_DONE : S_DIV;
      S_DIV:     state_d = S_DIVW;
      S_DIVW: begin
        if (div_rsp.done) state_d = (div_sel_q == 2'd3) ? S_BND : S_DIV;
      end
      S_BND:     state_d = loop_go ? S_RDA : S_DONE;
      S_RDA:     state_d = S_RDB;
      S_RDB:     state_d = S_CHK;
      S_CHK: begin
        if (blk) state_d = S_HIT;
        else if (k_q == hi_q[6:0]) state_d = S_BND;
        else state_d = S_RDA;
      end
      S_HIT:     state_d = S_DONE;
      S_DONE:    if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + ADDR_BITS'(1);
      if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          is_flag_q   <= !s_axis_tuser[1];
          is_clr_q    <= (cmd_e'(s_axis_tuser) == CMD_CLR);
          tile_ok_q   <= in_tile_ok;
          tile_addr_q <= {in_sy[ROW_BITS-1:0], in_sx[COL_BITS-1:0]};
          flags_q     <= in_flags;
          pos_q       <= in_pos;
          vert_q      <= in_vert;
          sp_q        <= in_vert ? in_sy : in_sx;
          ep_q        <= in_vert ? in_ey : in_ex;
          ss_q        <= in_vert ? in_sh : in_sw;
          es_q        <= in_vert ? in_eh : in_ew;
          sq_q        <= in_vert ? in_sx : in_sy;
          eq_q        <= in_vert ? in_ex : in_ey;
          sqs_q       <= in_vert ? in_sw : in_sh;
          eqs_q       <= in_vert ? in_ew : in_eh;
          ta_q        <= in_vert ? th_lsb : tw_lsb;
          tq_q        <= in_vert ? tw_lsb : th_lsb;
          ma_q        <= in_vert ? rows_used : cols_used;
          mq_q        <= in_vert ? cols_used : rows_used;
        end
      end
      S_FLAG_WR: begin
        res_hit_q   <= 1'b0;
        res_pos_q   <= '0;
        res_bnd_q   <= '1;
        res_solid_q <= 1'b0;
        res_s0_q    <= '1;
        res_s1_q    <= '1;
      end
      S_PREP: begin
        sedge_q   <= s_edge;
        eedge_q   <= e_edge;
        qmin_q    <= qmin_c;
        qmax_q    <= qmax_c;
        div_sel_q <= 2'd0;
        res_hit_q   <= 1'b0;
        res_pos_q   <= ep_q;
        res_bnd_q   <= '1;
        res_solid_q <= 1'b0;
        res_s0_q    <= '1;
        res_s1_q    <= '1;
      end
      S_DIV: dvd_neg_q <= dvd_sel[DVD_W-1];
      S_DIVW: begin
        if (div_rsp.done) begin
          div_sel_q <= div_sel_q + 2'd1;
          unique case (div_sel_q)
            2'd0: begin
              span0_q <= q_fix;
              lo_q    <= q_fix[QS_W-1] ? '0 : q_fix;
            end
            2'd1: begin
              span1_q <= q_fix;
              hi_q    <= (q_fix > $signed({14'b0, mq_q}) - QS_W'(1))
                         ? $signed({14'b0, mq_q}) - QS_W'(1) : q_fix;
            end
            2'd2: begin
              if (pos_q) b_q <= q_fix[QS_W-1] ? '0 : q_fix;
              else b_q <= (q_fix > $signed({14'b0, ma_q})) ? $signed({14'b0, ma_q}) : q_fix;
            end
            default: begin
              if (pos_q) b1_q <= (q_fix > $signed({14'b0, ma_q})) ? $signed({14'b0, ma_q}) : q_fix;
              else b1_q <= q_fix[QS_W-1] ? '0 : q_fix;
            end
          endcase
        end
      end
      S_BND: begin
        k_q       <= lo_q[6:0];
        solid_q   <= 1'b0;
        res_hit_q   <= 1'b0;
        res_pos_q   <= ep_q;
        res_bnd_q   <= '1;
        res_solid_q <= 1'b0;
        res_s0_q    <= sat14(span0_q);
        res_s1_q    <= sat14(span1_q);
      end
      S_RDA: va_q <= along_ok;
      S_RDB: begin
        vb_q <= along_ok;
        fa_q <= va_q ? mem_rdata : 8'h00;
      end
      S_CHK: begin
        solid_q     <= solid_q || solid_now;
        res_solid_q <= solid_q || solid_now;
        res_bnd_q   <= b_q[7:0];
        prod_q      <= b_q[6:0] * ta_q;
        if (!blk) begin
          if (k_q == hi_q[6:0]) b_q <= pos_q ? b_q + QS_W'(1) : b_q - QS_W'(1);
          else k_q <= k_q + 7'd1;
        end
      end
      S_HIT: begin
        res_hit_q <= 1'b1;
        res_pos_q <= sat18(hit_pos);
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_hit_q   <= res_hit_q;
          out_pos_q   <= res_pos_q;
          out_bnd_q   <= res_bnd_q;
          out_solid_q <= res_solid_q;
          out_s0_q    <= res_s0_q;
          out_s1_q    <= res_s1_q;
        end
      end
      default: ;
    endcase
  end

  // result port
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {1'b0, out_s1_q, out_s0_q, out_solid_q, out_bnd_q, out_pos_q};

  // checks
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_solid_needs_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tuser)
    else $error("solid flag without a hit");

  a_miss_no_boundary : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[25:18] == 8'hFF)
    else $error("boundary index set without a hit");

  a_write_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q == S_CLEAR || state_q == S_FLAG_WR))
    else $error("tile write outside clear or flag update");

endmodule
